// ----- design/assert_macros.svh -----
// Assertion macros used by the run list decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

// ----- design/drl_pkg.sv -----
// Types, constants and helpers of the run list decoder.
`timescale 1ns / 1ps

package drl_pkg;

  // Largest legal byte count of a length or offset field
  localparam int unsigned MAX_FIELD_BYTES_DEF = 8;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CFG_W     = 63;
  localparam int unsigned CNT_W     = 4;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned OUT_TDATA_W = 3 * VAL_W;

  // Header nibbles
  localparam logic [BYTE_W-1:0] LEN_MASK = 8'h0f;
  localparam logic [BYTE_W-1:0] OFF_MASK = 8'hf0;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_LENGTH = 2'd1,
    PH_OFFSET = 2'd2
  } drl_phase_e;

  // Result flags, lowest bit first: sparse, list_end, malformed
  typedef struct packed {
    logic malformed;
    logic list_end;
    logic sparse;
  } drl_flags_t;

  // Sign-extend a little-endian field of idx+1 bytes to 64 bits
  function automatic logic [VAL_W-1:0] sext_bytes(logic [VAL_W-1:0] v,
                                                  logic [IDX_W-1:0] idx);
    logic [VAL_W-1:0] keep;
    logic             sign;
    keep = {VAL_W{1'b1}} >> {~idx, 3'b000};
    sign = v[{idx, 3'b111}];
    return (v & keep) | (sign ? ~keep : '0);
  endfunction

endpackage

// ----- design/data_run_list_decoder.sv -----
// Run list decoder: one run-list byte in per cycle unless a waiting result stalls it, one run descriptor out.
//
// Usage:
//   s_axis carries the run list one byte per request; tuser set marks the
//   first byte of a new list, which reloads the running VCN from base_vcn
//   and clears the previous LCN. cfg writes base_vcn (63 bits) and is
//   always ready; write it only while the decoder is idle.
//   m_axis gives one result after the last byte of each run, after a zero
//   header (list_end) or after a field count above MAX_FIELD_BYTES
//   (malformed). After list_end or malformed, bytes are dropped until the
//   next list start.
// Timing:
//   One byte per cycle while no result waits. A result appears in the cycle
//   after its last byte is taken, set by the single result register; the
//   byte decode, sign extension and 64-bit VCN/LCN add sit between the
//   state registers and that result register.
// Reset and stall:
//   Reset clears all running values, base_vcn and the result valid bit.
//   While a result waits and m_axis_tready is low, s_axis_tready is low;
//   when the result is taken, a new byte is accepted in the same cycle.
`timescale 1ns / 1ps

module data_run_list_decoder #(
  parameter int unsigned MAX_FIELD_BYTES = drl_pkg::MAX_FIELD_BYTES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration: base_vcn
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [drl_pkg::CFG_W-1:0]           cfg_data_i,
  // input bytes
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [drl_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] run_byte
  input  logic                                s_axis_tuser,  // [0] list_start
  // results
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [63:0] run_start_vcn, [127:64] run_length, [191:128] run_lcn
  output logic [drl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [0] sparse, [1] list_end, [2] malformed
  output drl_pkg::drl_flags_t                 m_axis_tuser
);

  import drl_pkg::*;

  // state
  drl_phase_e         phase_q, phase_d;
  logic [CNT_W-1:0]   len_left_q, len_left_d;
  logic [CNT_W-1:0]   off_left_q, off_left_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [VAL_W-1:0]   len_acc_q, len_acc_d;
  logic [VAL_W-1:0]   off_acc_q, off_acc_d;
  logic [VAL_W-1:0]   next_vcn_q, next_vcn_d;
  logic [VAL_W-1:0]   prev_lcn_q, prev_lcn_d;
  logic               ended_q, ended_d;
  logic [CFG_W-1:0]   base_vcn_q;

  // result register
  logic               out_valid_q;
  logic [VAL_W-1:0]   out_vcn_q, out_len_q, out_lcn_q;
  drl_flags_t         out_flags_q;

  // decode outputs
  logic               emit;
  logic [VAL_W-1:0]   res_vcn, res_len, res_lcn;
  drl_flags_t         res_flags;

  // working values after a list start is applied
  drl_phase_e         eff_phase;
  logic               eff_ended;
  logic [VAL_W-1:0]   eff_vcn, eff_prev;
  logic [CNT_W-1:0]   ln, on;
  logic [VAL_W-1:0]   ins, len_fin, off_fin;
  logic               accept;

  // check terms
  logic               chk_end, chk_sparse, chk_drop;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Byte decode and run arithmetic
  always_comb begin
    eff_phase = s_axis_tuser ? PH_HEADER : phase_q;
    eff_ended = s_axis_tuser ? 1'b0 : ended_q;
    eff_vcn   = s_axis_tuser ? {1'b0, base_vcn_q} : next_vcn_q;
    eff_prev  = s_axis_tuser ? '0 : prev_lcn_q;

    ln  = CNT_W'(s_axis_tdata & LEN_MASK);
    on  = CNT_W'((s_axis_tdata & OFF_MASK) >> 4);
    ins = VAL_W'(s_axis_tdata) << {idx_q, 3'b000};
    len_fin = sext_bytes(len_acc_q | ins, idx_q);
    off_fin = sext_bytes(off_acc_q | ins, idx_q);

    phase_d    = phase_q;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    idx_d      = idx_q;
    len_acc_d  = len_acc_q;
    off_acc_d  = off_acc_q;
    next_vcn_d = next_vcn_q;
    prev_lcn_d = prev_lcn_q;
    ended_d    = ended_q;

    emit      = 1'b0;
    res_vcn   = '0;
    res_len   = '0;
    res_lcn   = '0;
    res_flags = '0;

    if (accept) begin
      // list start reloads the running values even if nothing else follows
      phase_d    = eff_phase;
      ended_d    = eff_ended;
      next_vcn_d = eff_vcn;
      prev_lcn_d = eff_prev;

      if (!eff_ended) begin
        unique case (eff_phase)
          PH_HEADER: begin
            if (s_axis_tdata == '0) begin
              emit               = 1'b1;
              res_flags.list_end = 1'b1;
              ended_d            = 1'b1;
            end else if (ln > CNT_W'(MAX_FIELD_BYTES) ||
                         on > CNT_W'(MAX_FIELD_BYTES)) begin
              emit                = 1'b1;
              res_flags.malformed = 1'b1;
              ended_d             = 1'b1;
            end else begin
              len_left_d = ln;
              off_left_d = on;
              idx_d      = '0;
              len_acc_d  = '0;
              off_acc_d  = '0;
              phase_d    = (ln != '0) ? PH_LENGTH : PH_OFFSET;
            end
          end
          PH_LENGTH: begin
            len_left_d = len_left_q - 1'b1;
            if (len_left_q != CNT_W'(1)) begin
              len_acc_d = len_acc_q | ins;
              idx_d     = idx_q + 1'b1;
            end else begin
              len_acc_d = len_fin;
              idx_d     = '0;
              if (off_left_q == '0) begin
                // sparse run: no offset, previous LCN kept
                emit             = 1'b1;
                res_vcn          = eff_vcn;
                res_len          = len_fin;
                res_flags.sparse = 1'b1;
                next_vcn_d       = eff_vcn + len_fin;
                phase_d          = PH_HEADER;
              end else begin
                phase_d = PH_OFFSET;
              end
            end
          end
          PH_OFFSET: begin
            off_left_d = off_left_q - 1'b1;
            if (off_left_q != CNT_W'(1)) begin
              off_acc_d = off_acc_q | ins;
              idx_d     = idx_q + 1'b1;
            end else begin
              off_acc_d  = off_fin;
              idx_d      = '0;
              emit       = 1'b1;
              res_vcn    = eff_vcn;
              res_len    = len_acc_q;
              res_lcn    = eff_prev + off_fin;
              next_vcn_d = eff_vcn + len_acc_q;
              prev_lcn_d = eff_prev + off_fin;
              phase_d    = PH_HEADER;
            end
          end
          default: begin
            phase_d = PH_HEADER;
          end
        endcase
      end
    end
  end

  // Decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      len_left_q  <= '0;
      off_left_q  <= '0;
      idx_q       <= '0;
      len_acc_q   <= '0;
      off_acc_q   <= '0;
      next_vcn_q  <= '0;
      prev_lcn_q  <= '0;
      ended_q     <= 1'b0;
      base_vcn_q  <= '0;
    end else begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      idx_q      <= idx_d;
      len_acc_q  <= len_acc_d;
      off_acc_q  <= off_acc_d;
      next_vcn_q <= next_vcn_d;
      prev_lcn_q <= prev_lcn_d;
      ended_q    <= ended_d;
      if (cfg_valid_i && cfg_ready_o) begin
        base_vcn_q <= cfg_data_i;
      end
    end
  end

  // Result register: valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      out_vcn_q   <= res_vcn;
      out_len_q   <= res_len;
      out_lcn_q   <= res_lcn;
      out_flags_q <= res_flags;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lcn_q, out_len_q, out_vcn_q};
  assign m_axis_tuser  = out_flags_q;

  // Checks
  assign chk_end    = m_axis_tvalid && (m_axis_tuser.list_end || m_axis_tuser.malformed);
  assign chk_sparse = m_axis_tvalid && m_axis_tuser.sparse;
  assign chk_drop   = accept && ended_q && !s_axis_tuser;

  `include "assert_macros.svh"

  `ASSERT_IMPL(a_one_flag, clk_i, rst_ni, m_axis_tvalid, $onehot0(m_axis_tuser))
  `ASSERT_IMPL(a_end_zero, clk_i, rst_ni, chk_end, m_axis_tdata == '0)
  `ASSERT_IMPL(a_sparse_lcn, clk_i, rst_ni, chk_sparse, m_axis_tdata[3*VAL_W-1:2*VAL_W] == '0)
  `ASSERT_NEXT(a_ended_quiet, clk_i, rst_ni, chk_drop, ended_q && (phase_q == $past(phase_q)))

endmodule
